[hw/rtl/edfc_pkg.sv]
// Shared types and constants for the fp80 / binary64 format converter.
package edfc_pkg;

  localparam int unsigned X_EXP_W   = 15;
  localparam int unsigned D_EXP_W   = 11;
  localparam int unsigned D_FRAC_W  = 52;
  localparam int unsigned SIG_W     = 64;

  // Request codes.
  localparam logic REQ_NARROW = 1'b0;
  localparam logic REQ_WIDEN  = 1'b1;

  // Bias difference between the fp80 and binary64 exponents.
  localparam logic [X_EXP_W-1:0] EXP_DELTA = 15'd15360;
  localparam logic [X_EXP_W-1:0] X_EXP_MAX = 15'h7FFF;
  localparam logic [D_EXP_W-1:0] D_EXP_MAX = 11'h7FF;

  typedef enum logic [2:0] {
    CLS_NORMAL = 3'd0,
    CLS_ZERO   = 3'd1,
    CLS_SUB    = 3'd2,
    CLS_INF    = 3'd3,
    CLS_NAN    = 3'd4
  } edfc_class_t;

  typedef struct packed {
    logic              req_type;
    logic [15:0]       operand_sign_exp;
    logic [SIG_W-1:0]  operand_bits;
  } edfc_req_t;

  typedef struct packed {
    logic [15:0]       result_sign_exp;
    logic [SIG_W-1:0]  result_bits;
    edfc_class_t       operand_class;
  } edfc_res_t;

endpackage

[hw/rtl/edfc_convert.sv]
// Combinational conversion datapath between fp80 and binary64.
module edfc_convert (
  input  edfc_pkg::edfc_req_t req,
  output edfc_pkg::edfc_res_t res
);
  import edfc_pkg::*;

  logic                 n_sign;
  logic [X_EXP_W-1:0]   n_exp;
  logic [52:0]          n_top;
  logic [X_EXP_W-1:0]   n_shift;
  logic [52:0]          n_den;
  logic [X_EXP_W-1:0]   n_dexp;
  logic [SIG_W-1:0]     n_word;
  edfc_class_t          n_class;

  logic                 w_sign;
  logic [D_EXP_W-1:0]   w_exp;
  logic [D_FRAC_W-1:0]  w_frac;
  logic [SIG_W-1:0]     w_norm;
  logic [5:0]           w_lz;
  logic [15:0]          w_se;
  logic [SIG_W-1:0]     w_sig;
  edfc_class_t          w_class;

  // Leading-zero normalization in six halving steps.
  always_comb begin
    w_norm = {req.operand_bits[D_FRAC_W-1:0], 11'b0};
    w_lz   = 6'd0;
    if (w_norm[63:32] == 32'd0) begin
      w_norm   = w_norm << 32;
      w_lz[5]  = 1'b1;
    end
    if (w_norm[63:48] == 16'd0) begin
      w_norm   = w_norm << 16;
      w_lz[4]  = 1'b1;
    end
    if (w_norm[63:56] == 8'd0) begin
      w_norm   = w_norm << 8;
      w_lz[3]  = 1'b1;
    end
    if (w_norm[63:60] == 4'd0) begin
      w_norm   = w_norm << 4;
      w_lz[2]  = 1'b1;
    end
    if (w_norm[63:62] == 2'd0) begin
      w_norm   = w_norm << 2;
      w_lz[1]  = 1'b1;
    end
    if (w_norm[63] == 1'b0) begin
      w_norm   = w_norm << 1;
      w_lz[0]  = 1'b1;
    end
  end

  // Narrowing: fp80 to binary64, truncating the significand.
  always_comb begin
    n_sign  = req.operand_sign_exp[15];
    n_exp   = req.operand_sign_exp[14:0];
    n_top   = req.operand_bits[63:11];
    n_shift = (EXP_DELTA + 15'd1) - n_exp;
    n_den   = (n_shift < 15'd64) ? (n_top >> n_shift[5:0]) : 53'd0;
    n_dexp  = n_exp - EXP_DELTA;
    priority if (n_exp == X_EXP_MAX) begin
      if (req.operand_bits[62:0] == 63'd0) begin
        n_word = {n_sign, D_EXP_MAX, 52'd0};
      end else if (!req.operand_bits[62]) begin
        n_word = {n_sign, D_EXP_MAX, 52'd1};
      end else begin
        n_word = {n_sign, D_EXP_MAX, 1'b1, 51'd0};
      end
    end else if (n_exp <= EXP_DELTA) begin
      n_word = {n_sign, 11'd0, n_den[D_FRAC_W-1:0]};
    end else if (n_dexp < {4'd0, D_EXP_MAX}) begin
      n_word = {n_sign, n_dexp[D_EXP_W-1:0], n_top[D_FRAC_W-1:0]};
    end else begin
      n_word = {n_sign, D_EXP_MAX, 52'd0};
    end

    priority if (n_exp == 15'd0 && req.operand_bits[62:0] != 63'd0) begin
      n_class = CLS_SUB;
    end else if (n_exp == 15'd0 && req.operand_bits == 64'd0) begin
      n_class = CLS_ZERO;
    end else if (n_exp == X_EXP_MAX) begin
      n_class = (req.operand_bits[62:0] == 63'd0) ? CLS_INF : CLS_NAN;
    end else begin
      n_class = CLS_NORMAL;
    end
  end

  // Widening: binary64 to fp80. The class follows from the binary64 fields,
  // since a binary64 denormal always widens to a normal fp80 value.
  always_comb begin
    w_sign = req.operand_bits[63];
    w_exp  = req.operand_bits[62:52];
    w_frac = req.operand_bits[D_FRAC_W-1:0];
    priority if (w_exp == D_EXP_MAX) begin
      w_se    = {w_sign, X_EXP_MAX};
      w_sig   = {1'b1, w_frac, 11'd0};
      w_class = (w_frac == 52'd0) ? CLS_INF : CLS_NAN;
    end else if (w_exp != 11'd0) begin
      w_se    = {w_sign, {4'd0, w_exp} + EXP_DELTA};
      w_sig   = {1'b1, w_frac, 11'd0};
      w_class = CLS_NORMAL;
    end else if (w_frac == 52'd0) begin
      w_se    = {w_sign, 15'd0};
      w_sig   = 64'd0;
      w_class = CLS_ZERO;
    end else begin
      w_se    = {w_sign, (EXP_DELTA + 15'd1) - {9'd0, w_lz}};
      w_sig   = w_norm;
      w_class = CLS_NORMAL;
    end
  end

  always_comb begin
    if (req.req_type == REQ_WIDEN) begin
      res.result_sign_exp = w_se;
      res.result_bits     = w_sig;
      res.operand_class   = w_class;
    end else begin
      res.result_sign_exp = 16'd0;
      res.result_bits     = n_word;
      res.operand_class   = n_class;
    end
  end

endmodule

[hw/rtl/extended_double_float_convert.sv]
// Top level of the fp80 / binary64 format converter.
//
// Requests enter on start with the payload on req; a request is taken at
// each rising edge where start is high and busy is low. busy stays low, so
// a new request may be issued in every cycle.
// req_type 0 narrows an fp80 value (operand_sign_exp, operand_bits) to a
// binary64 word; req_type 1 widens the binary64 word in operand_bits to fp80.
// Each request yields exactly one result on the result port, shown for one
// cycle with done high, after it passes the input register and then the
// conversion logic into the result register. Throughput is one request per
// cycle, in request order. Reset clears both valid flags, so no result
// appears from requests that were in flight at reset. The receiver cannot
// stall the block; it must take each result in the cycle that done marks.
module extended_double_float_convert (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  edfc_pkg::edfc_req_t req,
  output logic                done,
  output edfc_pkg::edfc_res_t result
);
  import edfc_pkg::*;

  logic      in_valid;
  edfc_req_t in_req;
  edfc_res_t conv_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
    if (in_valid) begin
      result <= conv_res;
    end
  end

  edfc_convert u_convert (
    .req (in_req),
    .res (conv_res)
  );

endmodule

[hw/rtl/edfc_checker.sv]
// Port-level checks for the format converter, bound to the top level.
module edfc_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input edfc_pkg::edfc_req_t req,
  input logic                done,
  input edfc_pkg::edfc_res_t result
);
  import edfc_pkg::*;

  // Every request is followed by its result with done high.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("request without result two cycles later");

  // No result appears without a matching earlier request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // Narrowing results carry a zero sign/exponent field.
  a_narrow_se: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.req_type == REQ_NARROW, 2) |-> result.result_sign_exp == 16'd0)
    else $error("narrowing result has nonzero sign/exponent");

  // A binary64 NaN widens to a value classed as NaN.
  a_widen_nan: assert property (@(posedge clk) disable iff (rst)
    done && $past(req.req_type == REQ_WIDEN && req.operand_bits[62:52] == 11'h7FF &&
                  req.operand_bits[51:0] != 52'd0, 2)
    |-> result.operand_class == CLS_NAN)
    else $error("widened NaN not classed as NaN");

endmodule

bind extended_double_float_convert edfc_checker u_edfc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);
